>>> hw/rtl/se_pkg.sv
// Shared constants and controller/datapath interface types for the sort engine.
`default_nettype none
package se_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 16;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W     = $clog2(DEPTH + 1);

  typedef struct packed {
    logic load;        // input request taken this cycle
    logic scan_start;  // begin a minimum search over the stored set
    logic emit;        // move the current minimum to the output register
  } se_cmd_t;

  typedef struct packed {
    logic scan_done;   // last stored entry compared this cycle
    logic emit_final;  // next emitted value closes the set
    logic out_free;    // output register can take a value this cycle
    logic scanning;    // reads in flight
  } se_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/se_datapath.sv
// Sort engine datapath: value store, minimum search, taken marks and output register.
`default_nettype none
module se_datapath
  import se_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire se_cmd_t               cmd,
  input  wire logic [VALUE_BITS-1:0] value,
  output se_stat_t                   stat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_BITS-1:0]      sorted_value,
  output logic                       end_of_run,
  output logic                       overflow
);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     emit_cnt;
  logic                  dropped;
  logic [DEPTH-1:0]      taken;

  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_issue;
  logic [ADDR_W-1:0]     rd_idx;
  logic                  rd_vld;
  logic [VALUE_BITS-1:0] rd_data;

  logic [VALUE_BITS-1:0] best_val;
  logic [ADDR_W-1:0]     best_idx;
  logic                  best_ok;

  logic                  full;
  logic [ADDR_W-1:0]     last_idx;
  logic                  take;
  logic                  final_one;

  assign full      = (fill == FILL_W'(DEPTH));
  assign last_idx  = ADDR_W'(fill - FILL_W'(1));
  assign take      = rd_vld && !taken[rd_idx] && (!best_ok || (rd_data < best_val));
  assign final_one = (emit_cnt == (fill - FILL_W'(1)));

  assign stat.scan_done  = rd_vld && (rd_idx == last_idx);
  assign stat.emit_final = final_one;
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.scanning   = rd_issue || rd_vld;

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[fill[ADDR_W-1:0]] <= value;
    end
    if (rd_issue) begin
      rd_data <= mem[rd_addr];
    end
    rd_idx <= rd_addr;
    if (take) begin
      best_val <= rd_data;
      best_idx <= rd_idx;
    end
    if (cmd.emit) begin
      sorted_value <= best_val;
      end_of_run   <= final_one;
      overflow     <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      emit_cnt  <= '0;
      dropped   <= 1'b0;
      taken     <= '0;
      rd_addr   <= '0;
      rd_issue  <= 1'b0;
      rd_vld    <= 1'b0;
      best_ok   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (!full) begin
          fill <= fill + FILL_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end

      if (take) begin
        best_ok <= 1'b1;
      end

      if (cmd.scan_start) begin
        rd_addr  <= '0;
        rd_issue <= 1'b1;
        best_ok  <= 1'b0;
      end else if (rd_issue) begin
        if (rd_addr == last_idx) begin
          rd_issue <= 1'b0;
        end else begin
          rd_addr <= rd_addr + ADDR_W'(1);
        end
      end
      rd_vld <= rd_issue;

      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (final_one) begin
          fill     <= '0;
          emit_cnt <= '0;
          dropped  <= 1'b0;
          taken    <= '0;
        end else begin
          emit_cnt        <= emit_cnt + FILL_W'(1);
          taken[best_idx] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/se_ctrl.sv
// Sort engine controller: load, scan and emit sequencing.
`default_nettype none
module se_ctrl
  import se_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     last,
  input  wire se_stat_t stat,
  output logic          in_ready,
  output se_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_LOAD);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    unique case (state)
      S_LOAD: begin
        cmd.load       = in_valid;
        cmd.scan_start = in_valid && last;
        if (in_valid && last) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.scan_start = !stat.emit_final;
          state_next     = stat.emit_final ? S_LOAD : S_SCAN;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sort_engine_ascending.sv
// Sort engine top level: collects a set of values and returns them in ascending order.
//
// Input channel (in_valid/in_ready, value, last): one value per request, one
// request per cycle while loading. The request with last set closes the set.
// Up to DEPTH values are stored; further values are dropped and the set's
// results carry overflow = 1.
// Output channel (out_valid/out_ready, sorted_value, end_of_run, overflow):
// one result per stored value, smallest first; end_of_run marks the final one.
// Flow: each result takes one minimum search over the n stored values
// through the single registered read port of the store, followed by a
// load of the output register. in_ready is low from the closing request
// until the final result has entered the output register; the next set
// loads while that result still waits.
// A stalled receiver holds the output register and delays the next emit and search.
// Reset empties the store, clears the overflow flag and marks the output register empty.
`default_nettype none
module sort_engine_ascending
  import se_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_BITS-1:0]      sorted_value,
  output logic                       end_of_run,
  output logic                       overflow
);

  se_cmd_t  cmd;
  se_stat_t stat;

  se_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  se_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .end_of_run   (end_of_run),
    .overflow     (overflow)
  );

  a_close_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last) |=> !in_ready)
    else $error("input accepted right after closing request");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("emit into occupied output register");

  a_no_load_while_scanning: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.scanning)
    else $error("input ready during minimum search");

endmodule
`default_nettype wire
